@@ rtl/dd_pkg.sv @@
// Shared types and constants for the date difference pipeline.
// Field widths, reciprocal constants for division by 100, month offset table.
// No dependencies.
package dd_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int OUT_W  = 22;

  // Largest year the input field can carry.
  localparam int YEAR_FIELD_MAX = (1 << YEAR_W) - 1;

  // Quotient widths for year/100 and year/400 over the full year field.
  localparam int Q100_W = 8;
  localparam int Q400_W = 6;

  // x/100 == (x * 5243) >> 19, exact for x below 2^14.
  localparam int RCP_W  = 13;
  localparam int RCP_SH = 19;
  localparam logic [RCP_W-1:0] RCP100 = 13'd5243;

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  localparam int MOFF_W = 9;

  // Stage one result for one date.
  typedef struct packed {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  mon;
    logic [YEAR_W-1:0] py;
    logic [Q100_W-1:0] q100;
    logic [Q400_W-1:0] q400;
  } dd_s1_t;

  // Days before the first of the month in a common year.
  function automatic logic [MOFF_W-1:0] dd_month_start(input logic [MON_W-1:0] mon);
    logic [MOFF_W-1:0] off;
    case (mon)
      4'd1:    off = 9'd0;
      4'd2:    off = 9'd31;
      4'd3:    off = 9'd59;
      4'd4:    off = 9'd90;
      4'd5:    off = 9'd120;
      4'd6:    off = 9'd151;
      4'd7:    off = 9'd181;
      4'd8:    off = 9'd212;
      4'd9:    off = 9'd243;
      4'd10:   off = 9'd273;
      4'd11:   off = 9'd304;
      4'd12:   off = 9'd334;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

@@ rtl/dd_year_prep.sv @@
// Stage one of one date: clamp month and year, form year-1 and its
// quotients by 100 and 400 through reciprocal multiplies. Uses dd_pkg.
module dd_year_prep #(
  parameter int YEAR_LIM = 9999
) (
  input  logic                       clk,
  input  logic [4:0]                 day,
  input  logic [3:0]                 month,
  input  logic [13:0]                year,
  output dd_pkg::dd_s1_t             s1_r
);
  import dd_pkg::*;

  localparam logic [YEAR_W-1:0] YR_MAX = YEAR_W'(YEAR_LIM);
  localparam int PROD_W = YEAR_W + RCP_W;

  logic [YEAR_W-1:0] yr_c;
  logic [YEAR_W-1:0] py_c;
  logic [MON_W-1:0]  mon_c;
  logic [YEAR_W-3:0] q4_c;
  logic [PROD_W-1:0] p100_c;
  logic [PROD_W-1:0] p400_c;
  dd_s1_t            s1_nxt;

  always_comb begin
    if (year == '0) begin
      yr_c = YEAR_W'(1);
    end else if (year > YR_MAX) begin
      yr_c = YR_MAX;
    end else begin
      yr_c = year;
    end
    if (month == '0) begin
      mon_c = MON_JAN;
    end else if (month > MON_DEC) begin
      mon_c = MON_DEC;
    end else begin
      mon_c = month;
    end
    py_c   = yr_c - YEAR_W'(1);
    q4_c   = py_c[YEAR_W-1:2];
    p100_c = PROD_W'(py_c) * PROD_W'(RCP100);
    p400_c = PROD_W'(q4_c) * PROD_W'(RCP100);
    s1_nxt.day  = day;
    s1_nxt.mon  = mon_c;
    s1_nxt.py   = py_c;
    s1_nxt.q100 = p100_c[RCP_SH +: Q100_W];
    s1_nxt.q400 = p400_c[RCP_SH +: Q400_W];
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

endmodule

@@ rtl/dd_day_count.sv @@
// Stages two and three of one date: day count of earlier years, leap test,
// month offset, then the final day number. Uses dd_pkg.
module dd_day_count #(
  parameter int DN_W = 22
) (
  input  logic                clk,
  input  dd_pkg::dd_s1_t      s1,
  output logic [DN_W-1:0]     dn_r
);
  import dd_pkg::*;

  localparam int MUL_W = YEAR_W + 9;

  logic [YEAR_W-1:0] m100_c;
  logic [YEAR_W-1:0] m400_c;
  logic [YEAR_W-1:0] r100_c;
  logic [YEAR_W-1:0] r400_c;
  logic [MUL_W-1:0]  x365_c;
  logic              leap_c;
  logic [DN_W-1:0]   yd_nxt;
  logic [DN_W-1:0]   yd_r;
  logic [MOFF_W-1:0] moff_r;
  logic              ladd_r;
  logic [DAY_W-1:0]  day_r;
  logic [DN_W-1:0]   dn_nxt;

  always_comb begin
    m100_c = (YEAR_W'(s1.q100) << 6) + (YEAR_W'(s1.q100) << 5) + (YEAR_W'(s1.q100) << 2);
    m400_c = (YEAR_W'(s1.q400) << 8) + (YEAR_W'(s1.q400) << 7) + (YEAR_W'(s1.q400) << 4);
    r100_c = s1.py - m100_c;
    r400_c = s1.py - m400_c;
    // year is leap when year-1 ends a block of 4 but not of 100, or ends a block of 400
    leap_c = ((s1.py[1:0] == 2'b11) && (r100_c != YEAR_W'(99))) || (r400_c == YEAR_W'(399));
    x365_c = MUL_W'(s1.py) * MUL_W'(365);
    yd_nxt = DN_W'(x365_c) + DN_W'(s1.py[YEAR_W-1:2]) - DN_W'(s1.q100) + DN_W'(s1.q400);
    dn_nxt = yd_r + DN_W'(moff_r) + DN_W'(ladd_r) + DN_W'(day_r);
  end

  always_ff @(posedge clk) begin
    yd_r   <= yd_nxt;
    moff_r <= dd_month_start(s1.mon);
    ladd_r <= leap_c && (s1.mon > MON_FEB);
    day_r  <= s1.day;
    dn_r   <= dn_nxt;
  end

endmodule

@@ rtl/date_difference_days.sv @@
// Gregorian date difference: absolute days between two dates, 4-stage pipeline.
// Registers in order: s1_r, then year days, month offset and leap bit, then dn_r,
// then diff_r; a valid shift register moves beside them and drives out_valid.
// Throughput: one item per cycle; busy never rises, so start may stay high.
// Reset (rst_n low, synchronous) drops every item in flight; no result follows.
// Results are not held: out_valid marks a single cycle, the receiver cannot stall.
// Depends on dd_pkg, dd_year_prep and dd_day_count.
module date_difference_days #(
  parameter int MAX_YEAR = 9999
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_first_day,
  input  logic [3:0]  in_first_month,
  input  logic [13:0] in_first_year,
  input  logic [4:0]  in_second_day,
  input  logic [3:0]  in_second_month,
  input  logic [13:0] in_second_year,
  output logic        out_valid,
  output logic [21:0] out_day_difference
);
  import dd_pkg::*;

  // Years beyond what the field holds never reach the clamp.
  localparam int YEAR_LIM = (MAX_YEAR > YEAR_FIELD_MAX) ? YEAR_FIELD_MAX : MAX_YEAR;
  // Day number width: whole years plus one year of months and days.
  localparam int DN_W = $clog2(YEAR_LIM * 366 + 64);

  logic            in_acc;
  logic [3:0]      vld_r;
  logic [3:0]      vld_nxt;
  dd_s1_t          s1_a;
  dd_s1_t          s1_b;
  logic [DN_W-1:0] dn_a;
  logic [DN_W-1:0] dn_b;
  logic [DN_W-1:0] diff_c;
  logic [OUT_W-1:0] diff_r;

  // The pipeline never stalls, so the block is always ready for an item.
  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  // Stage 1: clamp and reciprocal divides, one unit per date.
  dd_year_prep #(.YEAR_LIM(YEAR_LIM)) u_prep_a (
    .clk   (clk),
    .day   (in_first_day),
    .month (in_first_month),
    .year  (in_first_year),
    .s1_r  (s1_a)
  );

  dd_year_prep #(.YEAR_LIM(YEAR_LIM)) u_prep_b (
    .clk   (clk),
    .day   (in_second_day),
    .month (in_second_month),
    .year  (in_second_year),
    .s1_r  (s1_b)
  );

  // Stages 2 and 3: year days and leap test, then the day number.
  dd_day_count #(.DN_W(DN_W)) u_count_a (
    .clk  (clk),
    .s1   (s1_a),
    .dn_r (dn_a)
  );

  dd_day_count #(.DN_W(DN_W)) u_count_b (
    .clk  (clk),
    .s1   (s1_b),
    .dn_r (dn_b)
  );

  // Stage 4: magnitude of the difference, keep the low output bits.
  always_comb begin
    diff_c  = (dn_a > dn_b) ? (dn_a - dn_b) : (dn_b - dn_a);
    vld_nxt = {vld_r[2:0], in_acc};
  end

  always_ff @(posedge clk) begin
    diff_r <= OUT_W'(diff_c);
  end

  // Valid bits advance in lockstep with the payload stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid          = vld_r[3];
  assign out_day_difference = diff_r;

  // Every accepted item yields exactly one result once it has passed every pipeline stage.
  a_acc_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##4 out_valid)
    else $error("accepted item produced no result");

  // A result only appears for an item that was accepted and has passed every pipeline stage.
  a_out_from_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_acc, 4))
    else $error("result without an accepted item");

  // Identical dates give a zero difference.
  a_same_date_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_first_day == in_second_day) && (in_first_month == in_second_month)
     && (in_first_year == in_second_year)) |-> ##4 (out_valid && (out_day_difference == '0)))
    else $error("equal dates gave nonzero difference");

endmodule

@@ tb/sv/date_difference_days_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for date_difference_days: directed and random pairs of dates.
// Predicts day counts in the bench and checks each out_valid strobe in order.
// Depends on dd_pkg and the date_difference_days RTL.
module date_difference_days_tb;
  import dd_pkg::*;

  localparam int MAX_YEAR    = 9999;
  localparam int RANDOM_N    = 1200;
  localparam int DRAIN_WAIT  = 12;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_LIMIT  = 10;

  // One item: a pair of dates exactly as they sit on the input ports.
  typedef struct packed {
    logic [DAY_W-1:0]  first_day;
    logic [MON_W-1:0]  first_month;
    logic [YEAR_W-1:0] first_year;
    logic [DAY_W-1:0]  second_day;
    logic [MON_W-1:0]  second_month;
    logic [YEAR_W-1:0] second_year;
  } date_pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [DAY_W-1:0]  in_first_day = '0;
  logic [MON_W-1:0]  in_first_month = '0;
  logic [YEAR_W-1:0] in_first_year = '0;
  logic [DAY_W-1:0]  in_second_day = '0;
  logic [MON_W-1:0]  in_second_month = '0;
  logic [YEAR_W-1:0] in_second_year = '0;
  logic out_valid;
  logic [OUT_W-1:0] out_day_difference;

  date_pair_t pending_pairs[$];      // items not yet accepted, front is on the ports
  logic [OUT_W-1:0] expected_gaps[$]; // predicted differences, oldest first
  int total_pairs = 0;
  int pairs_sent = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // Days before the first of each month in a common year.
  int unsigned days_before_month[1:12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  date_difference_days #(.MAX_YEAR(MAX_YEAR)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_first_day      (in_first_day),
    .in_first_month    (in_first_month),
    .in_first_year     (in_first_year),
    .in_second_day     (in_second_day),
    .in_second_month   (in_second_month),
    .in_second_year    (in_second_year),
    .out_valid         (out_valid),
    .out_day_difference(out_day_difference)
  );

  // Day count from 1 January of year 1, plus one (the offset cancels in the gap).
  // Year and month saturate into range; the day is added without any check.
  function automatic int unsigned day_count(logic [DAY_W-1:0] d, logic [MON_W-1:0] m,
                                            logic [YEAR_W-1:0] y);
    int unsigned yr;
    int unsigned mo;
    int unsigned py;
    int unsigned n;
    bit is_leap;
    yr = (y == 0) ? 1 : ((y > MAX_YEAR) ? MAX_YEAR : y);
    mo = (m == 0) ? 1 : ((m > 12) ? 12 : m);
    py = yr - 1;
    n = py * 365 + py / 4 - py / 100 + py / 400;
    n += days_before_month[mo];
    is_leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    if (mo > 2 && is_leap) n += 1;
    return n + d;
  endfunction

  // Magnitude of the difference, cut to the output width.
  function automatic logic [OUT_W-1:0] predict_gap(date_pair_t p);
    int unsigned a;
    int unsigned b;
    a = day_count(p.first_day, p.first_month, p.first_year);
    b = day_count(p.second_day, p.second_month, p.second_year);
    return (a > b) ? OUT_W'(a - b) : OUT_W'(b - a);
  endfunction

  task automatic add_pair(int d1, int m1, int y1, int d2, int m2, int y2);
    date_pair_t p;
    p.first_day    = DAY_W'(d1);
    p.first_month  = MON_W'(m1);
    p.first_year   = YEAR_W'(y1);
    p.second_day   = DAY_W'(d2);
    p.second_month = MON_W'(m2);
    p.second_year  = YEAR_W'(y2);
    pending_pairs.push_back(p);
  endtask

  // Random pairs: mostly well-formed dates spread over the whole calendar, a share
  // of close pairs for small gaps, century and edge years for the leap rule, and
  // raw field noise that drives the saturation paths and every input bit.
  task automatic add_random_pair();
    int kind;
    int base;
    kind = $urandom_range(99);
    if (kind < 50) begin
      add_pair($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1, MAX_YEAR),
               $urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(1, MAX_YEAR));
    end else if (kind < 70) begin
      base = $urandom_range(1, MAX_YEAR - 2);
      add_pair($urandom_range(1, 31), $urandom_range(1, 12), base,
               $urandom_range(1, 31), $urandom_range(1, 12), base + $urandom_range(0, 2));
    end else if (kind < 80) begin
      base = $urandom_range(0, 3);
      case (base)
        0: base = $urandom_range(1, 5);
        1: base = MAX_YEAR - $urandom_range(0, 4);
        2: base = 100 * $urandom_range(1, 99);
        default: base = 400 * $urandom_range(1, 24);
      endcase
      add_pair($urandom_range(28, 29), 2, base,
               $urandom_range(1, 2), $urandom_range(2, 3), base + $urandom_range(0, 1));
    end else begin
      add_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold reset low from the start, then release it for good.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Driver: an item moves on an edge with start high and busy low. On that edge
  // predict its result and drop it from the queue, then present the next item or
  // idle. The idle share follows the progress through the list: light, heavy, none.
  always @(posedge clk) begin : drive_proc
    logic next_start;
    int idle_pct;
    date_pair_t p;
    next_start = start;
    if (rst_n) begin
      if (start && !busy) begin
        expected_gaps.push_back(predict_gap(pending_pairs[0]));
        void'(pending_pairs.pop_front());
        pairs_sent = pairs_sent + 1;
        next_start = 1'b0;
      end
      // A presented item that was not taken stays on the ports.
      if (!next_start && pending_pairs.size() != 0) begin
        if (pairs_sent < total_pairs / 3) idle_pct = 19;
        else if (pairs_sent < 2 * total_pairs / 3) idle_pct = 79;
        else idle_pct = 0;
        if ($urandom_range(99) >= idle_pct) begin
          p = pending_pairs[0];
          next_start = 1'b1;
          in_first_day    <= p.first_day;
          in_first_month  <= p.first_month;
          in_first_year   <= p.first_year;
          in_second_day   <= p.second_day;
          in_second_month <= p.second_month;
          in_second_year  <= p.second_year;
        end
      end
    end
    start <= next_start;
  end

  // Monitor: every strobe is one result; compare it with the oldest prediction.
  always @(posedge clk) begin : check_proc
    logic [OUT_W-1:0] want;
    if (rst_n && out_valid) begin
      if (expected_gaps.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= SHOW_LIMIT)
          $display("unexpected result: day_difference %0d", out_day_difference);
      end else begin
        want = expected_gaps.pop_front();
        if (out_day_difference !== want) begin
          fail_count = fail_count + 1;
          if (fail_count <= SHOW_LIMIT)
            $display("day_difference mismatch: expected %0d, got %0d", want,
                     out_day_difference);
        end
      end
    end
  end

  initial begin
    // Range ends in both orders, and a date against itself.
    add_pair(1, 1, 1, 31, 12, MAX_YEAR);
    add_pair(31, 12, MAX_YEAR, 1, 1, 1);
    add_pair(15, 6, 2024, 15, 6, 2024);
    // Leap rule: a 400-year, a plain century, an ordinary leap year.
    add_pair(28, 2, 2000, 1, 3, 2000);
    add_pair(28, 2, 1900, 1, 3, 1900);
    add_pair(29, 2, 2004, 1, 3, 2004);
    add_pair(1, 1, 1999, 1, 1, 2000);
    add_pair(1, 1, 2000, 1, 1, 2001);
    // Day past the end of its month, day zero.
    add_pair(31, 2, 2001, 3, 3, 2001);
    add_pair(31, 2, 2004, 1, 3, 2004);
    add_pair(0, 3, 2010, 28, 2, 2010);
    add_pair(0, 1, 1, 1, 1, 1);
    // Month zero and months past December saturate.
    add_pair(10, 0, 1500, 10, 1, 1500);
    add_pair(10, 13, 1500, 10, 12, 1500);
    add_pair(5, 15, 7777, 5, 0, 7777);
    // Year zero and years past the top saturate.
    add_pair(1, 1, 0, 1, 1, 1);
    add_pair(1, 1, MAX_YEAR + 1, 1, 1, MAX_YEAR);
    add_pair(31, 15, YEAR_FIELD_MAX, 0, 0, 0);
    add_pair(0, 0, 0, 31, 15, YEAR_FIELD_MAX);
    add_pair(31, 12, MAX_YEAR, 30, 12, MAX_YEAR);
    add_pair(1, 1, 400, 1, 1, 401);
    repeat (RANDOM_N) add_random_pair();
    total_pairs = pending_pairs.size();

    @(posedge clk);
    while (!rst_n || pending_pairs.size() != 0 || expected_gaps.size() != 0)
      @(posedge clk);
    // Let any stray strobe show up before the verdict.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_gaps.size() != 0) fail_count = fail_count + 1;
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
